// ----- design/efr_pkg.sv -----
// Shared types and constants for the escaped frame receiver.
// No dependencies.
package efr_pkg;

    localparam logic [7:0] BYTE_BEGIN = 8'hFF;
    localparam logic [7:0] BYTE_END   = 8'hFE;
    localparam logic [7:0] BYTE_ACK   = 8'hFD;
    localparam logic [7:0] BYTE_ERR   = 8'hFC;

    localparam logic [7:0] ESCAPE_CODE_RESET = 8'hFB;
    localparam logic [7:0] MAX_LENGTH_RESET  = 8'd240;

    localparam logic REG_ESCAPE_CODE = 1'b0;
    localparam logic REG_MAX_LENGTH  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_ID   = 3'd2,
        PH_XOR  = 3'd3,
        PH_DATA = 3'd4,
        PH_ESC  = 3'd5,
        PH_PACK = 3'd6,
        PH_PERR = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        K_PAYLOAD = 3'd0,
        K_GOOD    = 3'd1,
        K_BAD     = 3'd2,
        K_REJECT  = 3'd3,
        K_PEERACK = 3'd4,
        K_PEERERR = 3'd5
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] value;
    } t_result;

endpackage

// ----- design/efr_parser.sv -----
// Frame parser: phase state machine, length count and XOR check.
// Uses efr_pkg; produces at most one result per processed byte.
module efr_parser import efr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_escape_code,
    input  logic [7:0] i_max_length,
    output t_result    o_res
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_remaining, n_remaining;
    logic       r_underflow, n_underflow;
    logic [7:0] r_frame_id, n_frame_id;
    logic [7:0] r_expected_xor, n_expected_xor;
    logic [7:0] r_running_xor, n_running_xor;

    logic       w_is_end;
    logic       w_is_esc;
    logic       w_len_ok;
    logic       w_good;

    assign w_is_end = (i_byte == BYTE_END);
    assign w_is_esc = (i_byte == i_escape_code);
    assign w_len_ok = (i_byte <= i_max_length);
    assign w_good   = (r_running_xor == r_expected_xor) && (r_remaining == 8'd0)
                      && !r_underflow;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (i_byte == BYTE_BEGIN) begin
                    n_phase = PH_LEN;
                end else if (i_byte == BYTE_ACK) begin
                    n_phase = PH_PACK;
                end else if (i_byte == BYTE_ERR) begin
                    n_phase = PH_PERR;
                end
            end
            PH_LEN:  n_phase = w_len_ok ? PH_ID : PH_IDLE;
            PH_ID:   n_phase = PH_XOR;
            PH_XOR:  n_phase = PH_DATA;
            PH_DATA: begin
                if (w_is_end) begin
                    n_phase = PH_IDLE;
                end else if (w_is_esc) begin
                    n_phase = PH_ESC;
                end
            end
            PH_ESC:  n_phase = PH_DATA;
            default: n_phase = PH_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_remaining    = r_remaining;
        n_underflow    = r_underflow;
        n_frame_id     = r_frame_id;
        n_expected_xor = r_expected_xor;
        n_running_xor  = r_running_xor;
        o_res.valid    = 1'b0;
        o_res.kind     = K_PAYLOAD;
        o_res.value    = i_byte;
        case (r_phase)
            PH_IDLE: ;
            PH_LEN: begin
                if (w_len_ok) begin
                    n_remaining = i_byte;
                    n_underflow = 1'b0;
                end else begin
                    o_res.valid = 1'b1;
                    o_res.kind  = K_REJECT;
                    o_res.value = r_frame_id;
                end
            end
            PH_ID:  n_frame_id = i_byte;
            PH_XOR: begin
                n_expected_xor = i_byte;
                n_running_xor  = 8'd0;
            end
            PH_DATA, PH_ESC: begin
                if (r_phase == PH_DATA && w_is_end) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = w_good ? K_GOOD : K_BAD;
                    o_res.value = r_frame_id;
                end else begin
                    // escape bytes count toward length and XOR too
                    if (r_remaining == 8'd0) begin
                        n_underflow = 1'b1;
                    end else begin
                        n_remaining = r_remaining - 8'd1;
                    end
                    n_running_xor = r_running_xor ^ i_byte;
                    o_res.valid   = !(r_phase == PH_DATA && w_is_esc);
                end
            end
            PH_PACK: begin
                o_res.valid = 1'b1;
                o_res.kind  = K_PEERACK;
            end
            default: begin
                o_res.valid = 1'b1;
                o_res.kind  = K_PEERERR;
            end
        endcase
        if (!i_step) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_remaining    <= 8'd0;
            r_underflow    <= 1'b0;
            r_frame_id     <= 8'd0;
            r_expected_xor <= 8'd0;
            r_running_xor  <= 8'd0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_remaining    <= n_remaining;
            r_underflow    <= n_underflow;
            r_frame_id     <= n_frame_id;
            r_expected_xor <= n_expected_xor;
            r_running_xor  <= n_running_xor;
        end
    end

endmodule

// ----- design/escaped_frame_receiver.sv -----
// A byte transfer loads the input register; the parser works on it combinationally and its
// result is loaded into the result register, from which it transfers out.
// Throughput: one byte per cycle unless stalled; phase update and XOR are combinational.
// Input stalls only while both input and result registers are full and output is stalled.
// Reset (synchronous, active low): parser state cleared to idle, escape_code 0xFB,
// max_length 240, both pipeline stages emptied. Depends on efr_pkg and efr_parser.
module escaped_frame_receiver import efr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_value,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_escape_code;
    logic [7:0] r_max_length;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_kind      r_kind;
    logic [7:0] r_value;
    logic       w_advance;
    t_result    w_res;

    // advance when the result register is empty or being drained
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_code <= ESCAPE_CODE_RESET;
            r_max_length  <= MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ESCAPE_CODE: r_escape_code <= i_cfg_data;
                REG_MAX_LENGTH:  r_max_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    efr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (r_in_valid && w_advance),
        .i_byte        (r_in_byte),
        .i_escape_code (r_escape_code),
        .i_max_length  (r_max_length),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res.valid) begin
            r_kind  <= w_res.kind;
            r_value <= w_res.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;

endmodule
